// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the hash table engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/fnvht_pkg.sv =====
// Shared types and constants of the FNV-1a hash table engine.
`timescale 1ns / 1ps
package fnvht_pkg;
  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned KEY_BYTES_DEF   = 8;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
  // The FNV prime is 2^40 + 0x1b3, so a multiply is a shift plus a small product.
  localparam int unsigned FNV_PRIME_SHIFT = 40;
  localparam logic [63:0] FNV_PRIME_LOW   = 64'h00000000000001b3;

  localparam int unsigned LOAD_NUM = 7;
  localparam int unsigned LOAD_DEN = 10;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  // One hashed request on its way from the front end to the probe engine.
  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [3:0]  len;
    logic [31:0] val;
    logic [15:0] slot;
  } req_t;

  // One finished result.
  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    status_t     status;
    logic [10:0] count;
  } res_t;
endpackage

// ===== rtl/fnv1a_linear_probe_hash_table.sv =====
// Top level of the FNV-1a open-addressing hash table engine.
// Key-value table engine with queue-style ports. A transaction pushed on the input side
// carries an opcode (get or set), a key of up to KEY_BYTES bytes with its length, and a
// value. The front end hashes the key with 64-bit FNV-1a, one key byte per cycle, and
// hands the request to the back end through a two-entry queue. The back end probes the
// slot memory linearly from the masked hash; each slot visited takes a memory read, then
// a compare and update, and each request is taken in the idle state and leaves through
// the result state. The slower of the two parts sets the sustained rate. A get returns
// hit and the stored value, or zero on a miss. A set updates an existing key, or inserts
// a new key unless the occupied count has reached load_limit or no empty slot exists
// (status 1); a zero value is rejected with status 2. Every transaction yields one result
// transaction carrying the occupied count after the operation. After reset the back end
// clears the slot memory, one slot per cycle, and full stays high during that pass;
// load_limit writes are taken at any time.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fnv1a_linear_probe_hash_table #(
  parameter int unsigned TABLE_SLOTS = fnvht_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned KEY_BYTES   = fnvht_pkg::KEY_BYTES_DEF,
  parameter int unsigned VALUE_BITS  = fnvht_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [63:0] key_bytes,
  input  logic [3:0]  key_length,
  input  logic [31:0] value_in,
  output logic        empty,
  input  logic        pop,
  output logic        hit,
  output logic [31:0] value_out,
  output logic [1:0]  status,
  output logic [10:0] entry_count
);
  import fnvht_pkg::*;

  localparam logic [10:0] LIMIT_RESET = 11'((TABLE_SLOTS * LOAD_NUM / LOAD_DEN) % 2048);

  logic [10:0] load_limit;
  logic        front_busy;
  logic        clearing;
  logic        accept;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  req_t        q_wr;
  req_t        q_rd;
  logic        res_valid;
  res_t        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      load_limit <= cfg_wdata;
    end
  end

  // The front end holds one request while hashing; the memory clear blocks new work.
  assign full   = front_busy || clearing;
  assign accept = push && !full;

  fnvht_hash #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_hash (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (opcode),
    .key_bytes  (key_bytes),
    .key_length (key_length),
    .value_in   (value_in),
    .busy       (front_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wr)
  );

  fnvht_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  fnvht_probe #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_probe (
    .clk        (clk),
    .rst        (rst),
    .load_limit (load_limit),
    .q_empty    (q_empty),
    .q_data     (q_rd),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (pop)
  );

  // The result register is the output side of the queue interface.
  assign empty       = !res_valid;
  assign hit         = res.hit;
  assign value_out   = res.value;
  assign status      = res.status;
  assign entry_count = res.count;

  // No request may be taken while the slot memory is being cleared.
  `ASSERT_IMPLY(a_clear_blocks, clk, rst, clearing, full)
  // A rejected zero-value set never reports a hit or a value.
  `ASSERT_IMPLY(a_zero_clean, clk, rst, !empty && status == ST_ZERO, !hit && value_out == 32'd0)
  // A refused insert is never a hit.
  `ASSERT_IMPLY(a_full_miss, clk, rst, !empty && status == ST_FULL, !hit)
  // A pop without a push always leaves room in the queue.
  `ASSERT_NEXT(a_pop_drains, clk, rst, q_pop && !q_push && q_empty == 1'b0, !q_full)
endmodule

// ===== rtl/fnvht_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module fnvht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/fnvht_hash.sv =====
// Front end: takes a request, clamps and masks the key, hashes it one byte per cycle.
`timescale 1ns / 1ps
module fnvht_hash #(
  parameter int unsigned KEY_BYTES  = fnvht_pkg::KEY_BYTES_DEF,
  parameter int unsigned VALUE_BITS = fnvht_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               opcode,
  input  logic [63:0]        key_bytes,
  input  logic [3:0]         key_length,
  input  logic [31:0]        value_in,
  output logic               busy,
  input  logic               q_full,
  output logic               q_push,
  output fnvht_pkg::req_t    q_data
);
  import fnvht_pkg::*;

  localparam int unsigned KW = KEY_BYTES * 8;
  localparam int unsigned VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  logic          op;
  logic [KW-1:0] key;
  logic [3:0]    len;
  logic [VW-1:0] val;
  logic [63:0]   h;
  logic [3:0]    cnt;

  logic [3:0]    len_c;
  logic [63:0]   key_m;
  logic [7:0]    byte_sel;
  logic [63:0]   x;
  logic [63:0]   h_next;

  always_comb begin
    len_c = (key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length;
    if (len_c >= 4'd8) begin
      key_m = key_bytes;
    end else begin
      key_m = key_bytes & ((64'd1 << {len_c, 3'b000}) - 64'd1);
    end
    byte_sel = 8'(key >> {cnt, 3'b000});
    x        = h ^ {56'd0, byte_sel};
    h_next   = (x << FNV_PRIME_SHIFT) + (x * FNV_PRIME_LOW);
  end

  assign q_push      = busy && (cnt == len) && !q_full;
  assign q_data.op   = op;
  assign q_data.key  = 64'(key);
  assign q_data.len  = len;
  assign q_data.val  = 32'(val);
  assign q_data.slot = h[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
      op   <= opcode;
      key  <= key_m[KW-1:0];
      len  <= len_c;
      val  <= value_in[VW-1:0];
      h    <= FNV_BASIS;
      cnt  <= 4'd0;
    end else if (busy) begin
      if (cnt != len) begin
        h   <= h_next;
        cnt <= cnt + 4'd1;
      end else if (!q_full) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/fnvht_fifo.sv =====
// Two-entry queue that decouples the hashing front end from the probe engine.
`timescale 1ns / 1ps
module fnvht_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fnvht_pkg::req_t wr_data,
  output logic            full,
  input  logic            pop,
  output fnvht_pkg::req_t rd_data,
  output logic            empty
);
  import fnvht_pkg::*;

  req_t       mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) begin
        mem[wp] <= wr_data;
        wp      <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

// ===== rtl/fnvht_probe.sv =====
// Back end: clears the slot memory, then probes linearly and updates the table.
`timescale 1ns / 1ps
module fnvht_probe #(
  parameter int unsigned TABLE_SLOTS = fnvht_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned KEY_BYTES   = fnvht_pkg::KEY_BYTES_DEF,
  parameter int unsigned VALUE_BITS  = fnvht_pkg::VALUE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [10:0]     load_limit,
  input  logic            q_empty,
  input  fnvht_pkg::req_t q_data,
  output logic            q_pop,
  output logic            clearing,
  output logic            res_valid,
  output fnvht_pkg::res_t res,
  input  logic            res_pop
);
  import fnvht_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned KW = KEY_BYTES * 8;
  localparam int unsigned VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int unsigned EW = 1 + 4 + KW + VW;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CMP, S_RESP} state_t;

  state_t        state;
  logic [AW-1:0] idx;
  logic [AW-1:0] visited;
  logic          op;
  logic [KW-1:0] key;
  logic [3:0]    len;
  logic [VW-1:0] val;
  logic [10:0]   count;
  res_t          pend;

  logic          we;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] rd_data;
  logic          e_valid;
  logic [3:0]    e_len;
  logic [KW-1:0] e_key;
  logic [VW-1:0] e_val;
  logic          is_empty;
  logic          is_match;

  assign {e_valid, e_len, e_key, e_val} = rd_data;
  assign is_empty = !e_valid;
  assign is_match = e_valid && (e_len == len) && (e_key == key);
  assign clearing = (state == S_CLEAR);
  assign q_pop    = (state == S_IDLE) && !q_empty;

  always_comb begin
    we      = 1'b0;
    wr_addr = idx;
    wr_data = {1'b1, len, key, val};
    if (state == S_CLEAR) begin
      we      = 1'b1;
      wr_data = '0;
    end else if (state == S_CMP && op == OP_SET) begin
      we = is_match || (is_empty && count < load_limit);
    end
  end

  fnvht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .re      (state == S_READ),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      count     <= 11'd0;
      res_valid <= 1'b0;
    end else begin
      // The result state posts its own flag, so only drop it elsewhere.
      if (res_pop && res_valid && state != S_RESP) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == AW'(TABLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            op      <= q_data.op;
            key     <= q_data.key[KW-1:0];
            len     <= q_data.len;
            val     <= q_data.val[VW-1:0];
            idx     <= q_data.slot[AW-1:0];
            visited <= '0;
            if (q_data.op == OP_SET && q_data.val[VW-1:0] == '0) begin
              pend  <= '{hit: 1'b0, value: 32'd0, status: ST_ZERO, count: count};
              state <= S_RESP;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          state <= S_RESP;
          if (is_match) begin
            pend <= '{hit: 1'b1, value: (op == OP_GET) ? 32'(e_val) : 32'd0,
                      status: ST_OK, count: count};
          end else if (is_empty) begin
            if (op == OP_GET) begin
              pend <= '{hit: 1'b0, value: 32'd0, status: ST_OK, count: count};
            end else if (count >= load_limit) begin
              pend <= '{hit: 1'b0, value: 32'd0, status: ST_FULL, count: count};
            end else begin
              count <= count + 11'd1;
              pend  <= '{hit: 1'b0, value: 32'd0, status: ST_OK, count: count + 11'd1};
            end
          end else if (visited == AW'(TABLE_SLOTS - 1)) begin
            pend <= '{hit: 1'b0, value: 32'd0,
                      status: (op == OP_SET) ? ST_FULL : ST_OK, count: count};
          end else begin
            idx     <= idx + 1'b1;
            visited <= visited + 1'b1;
            state   <= S_READ;
          end
        end
        S_RESP: begin
          if (!res_valid || res_pop) begin
            res       <= pend;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the FNV-1a linear-probe hash table engine.
`timescale 1ns / 1ps
module tb;
  import fnvht_pkg::*;

  localparam int unsigned SLOTS = 1024;
  localparam logic [63:0] FNV_MULT = 64'h00000100000001b3;
  localparam int unsigned SETTLE = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        push = 1'b0;
  logic        full;
  logic        opcode = OP_GET;
  logic [63:0] key_bytes = '0;
  logic [3:0]  key_length = '0;
  logic [31:0] value_in = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        hit;
  logic [31:0] value_out;
  logic [1:0]  status;
  logic [10:0] entry_count;

  fnv1a_linear_probe_hash_table dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .opcode(opcode), .key_bytes(key_bytes),
    .key_length(key_length), .value_in(value_in), .empty(empty), .pop(pop),
    .hit(hit), .value_out(value_out), .status(status), .entry_count(entry_count)
  );

  // Shadow copy of the table contents and the load limit register.
  logic [63:0] tbl_key [SLOTS];
  logic [3:0]  tbl_len [SLOTS];
  logic [31:0] tbl_val [SLOTS];
  bit          tbl_used [SLOTS];
  int unsigned tbl_count;
  int unsigned tbl_limit;

  res_t        pending_results[$];
  int          mismatches;
  int          results_seen;
  int          hits_seen;
  int          refusals_seen;
  bit          calm;

  // Key pool so that random traffic revisits earlier keys and produces hits.
  logic [63:0] pool_key [32];
  logic [3:0]  pool_len [32];

  initial forever #10 clk = ~clk;

  initial begin
    #100ms;
    $display("FAIL fnv1a_linear_probe_hash_table");
    $finish;
  end

  function automatic logic [63:0] key_mask(input int unsigned n);
    return (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  function automatic logic [63:0] fnv1a(input logic [63:0] k, input int unsigned n);
    logic [63:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < n; i++) begin
      h = (h ^ {56'd0, k[8*i +: 8]}) * FNV_MULT;
    end
    return h;
  endfunction

  // Apply one request to the shadow table and return the result it should produce.
  function automatic res_t table_step(input logic op, input logic [63:0] kin,
                                      input logic [3:0] lin, input logic [31:0] v);
    res_t        r;
    int unsigned n;
    int unsigned idx;
    int unsigned free_idx;
    bit          found;
    bit          has_free;
    logic [63:0] k;
    n = (lin > 8) ? 8 : lin;
    k = kin & key_mask(n);
    r = '0;
    r.status = ST_OK;
    found = 0;
    has_free = 0;
    free_idx = 0;
    if (op == OP_SET && v == 0) begin
      r.status = ST_ZERO;
    end else begin
      idx = 32'(fnv1a(k, n) & 64'(SLOTS - 1));
      for (int p = 0; p < SLOTS; p++) begin
        if (!tbl_used[idx]) begin
          has_free = 1;
          free_idx = idx;
          break;
        end
        if (tbl_len[idx] == n && tbl_key[idx] == k) begin
          found = 1;
          break;
        end
        idx = (idx + 1) & (SLOTS - 1);
      end
      if (op == OP_GET) begin
        if (found) begin
          r.hit = 1'b1;
          r.value = tbl_val[idx];
        end
      end else if (found) begin
        r.hit = 1'b1;
        tbl_val[idx] = v;
      end else if (tbl_count >= tbl_limit || !has_free) begin
        r.status = ST_FULL;
      end else begin
        tbl_key[free_idx] = k;
        tbl_len[free_idx] = 4'(n);
        tbl_val[free_idx] = v;
        tbl_used[free_idx] = 1;
        tbl_count++;
      end
    end
    r.count = 11'(tbl_count);
    return r;
  endfunction

  // Sender: one transaction per call; push stays high until the next gap.
  task automatic send_item(input logic op, input logic [63:0] k, input logic [3:0] n,
                           input logic [31:0] v);
    if (!calm && $urandom_range(99) < 23) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    opcode <= op;
    key_bytes <= k;
    key_length <= n;
    value_in <= v;
    do @(posedge clk); while (full);
    pending_results.push_back(table_step(op, k, n, v));
  endtask

  // Stop sending and wait until every expected result has been popped.
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input int unsigned lim);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lim[10:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    tbl_limit = lim;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick a pooled key; bytes past its length get random filler, which must be ignored.
  task automatic send_pooled(input logic op, input logic [31:0] v);
    int unsigned j;
    logic [63:0] m;
    logic [3:0]  n;
    j = $urandom_range(31);
    m = key_mask(pool_len[j]);
    n = (pool_len[j] == 8) ? 4'($urandom_range(8, 15)) : pool_len[j];
    send_item(op, (pool_key[j] & m) | (rand64() & ~m), n, v);
  endtask

  // Receiver: pops at random, and always during calm stretches.
  always @(negedge clk) begin
    pop <= calm || ($urandom_range(99) >= 23);
  end

  // Compare each popped transaction with the oldest expected result.
  always @(posedge clk) begin
    res_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: hit=%0d value=%0h status=%0d count=%0d",
               hit, value_out, status, entry_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (want.hit) hits_seen++;
        if (want.status == ST_FULL) refusals_seen++;
        if (hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, hit);
          mismatches++;
        end
        if (value_out !== want.value) begin
          $error("value_out: expected %0h, actual %0h", want.value, value_out);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatches++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
          mismatches++;
        end
      end
    end
  end

  // Corner requests: empty key, long lengths, filler bytes, zero and maximal values.
  task automatic test_directed();
    send_item(OP_GET, 64'd0, 4'd0, 32'd0);
    send_item(OP_SET, 64'd0, 4'd0, 32'd0);
    send_item(OP_SET, 64'hdead, 4'd0, 32'hffffffff);
    send_item(OP_GET, 64'd0, 4'd0, 32'd0);
    send_item(OP_SET, '1, 4'd8, 32'd1);
    send_item(OP_GET, '1, 4'd15, 32'd0);
    send_item(OP_SET, '1, 4'd12, 32'h80000000);
    send_item(OP_GET, '1, 4'd8, 32'hffffffff);
    send_item(OP_SET, 64'h00000000000000ab, 4'd1, 32'h12345678);
    send_item(OP_GET, 64'hffffffffffffffab, 4'd1, 32'd0);
    send_item(OP_GET, 64'h00000000000000ab, 4'd2, 32'd0);
    send_item(OP_SET, 64'h123456789abcdef0, 4'd7, 32'h5a5a5a5a);
    send_item(OP_GET, 64'hff3456789abcdef0, 4'd7, 32'd0);
    send_item(OP_SET, 64'h123456789abcdef0, 4'd7, 32'd0);
    send_item(OP_SET, 64'h123456789abcdef0, 4'd7, 32'ha5a5a5a5);
    send_item(OP_GET, 64'h003456789abcdef0, 4'd7, 32'd0);
    send_item(OP_GET, 64'h5555555555555555, 4'd8, 32'd0);
    send_item(OP_SET, 64'haaaaaaaaaaaaaaaa, 4'd15, 32'h7fffffff);
    send_item(OP_GET, 64'haaaaaaaaaaaaaaaa, 4'd9, 32'd0);
  endtask

  // Mixed gets and sets, mostly over the key pool, with a calm stretch in the middle.
  task automatic test_random_mix(input int items);
    for (int i = 0; i < items; i++) begin
      calm = (i >= items / 3 && i < items / 2);
      case ($urandom_range(9))
        0: send_pooled(OP_SET, 32'd0);
        1, 2, 3, 4: send_pooled(OP_SET, ($urandom_range(7) == 0) ? 32'hffffffff : $urandom);
        5: send_item(OP_GET, rand64(), 4'($urandom_range(15)), $urandom);
        default: send_pooled(OP_GET, $urandom);
      endcase
    end
    calm = 0;
  endtask

  // With the limit at zero, new keys are refused while updates still land.
  task automatic test_limit_zero();
    write_limit(0);
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_item(OP_SET, rand64(), 4'($urandom_range(1, 15)), $urandom | 1);
      else send_pooled(i % 3 == 1 ? OP_SET : OP_GET, $urandom | 1);
    end
  endtask

  // Raise the limit to every slot, fill the table, then probe a full table.
  task automatic test_fill_table();
    write_limit(SLOTS);
    while (tbl_count < SLOTS) begin
      send_item(OP_SET, rand64(), 4'($urandom_range(4, 15)), $urandom | 1);
    end
    for (int i = 0; i < 6; i++) begin
      send_item(OP_SET, rand64(), 4'd8, $urandom | 1);
      send_item(OP_GET, rand64(), 4'd8, 32'd0);
      send_pooled(OP_GET, 32'd0);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) tbl_used[i] = 0;
    for (int j = 0; j < 32; j++) begin
      pool_key[j] = rand64();
      pool_len[j] = 4'($urandom_range(8));
    end
    tbl_count = 0;
    tbl_limit = (SLOTS * LOAD_NUM) / LOAD_DEN;
    mismatches = 0;
    results_seen = 0;
    hits_seen = 0;
    refusals_seen = 0;
    calm = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    drain();
    test_random_mix(120);
    write_limit(3);
    test_random_mix(60);
    write_limit(1500 % 2048 > 1024 ? 700 : 0);
    test_random_mix(40);
    test_limit_zero();
    write_limit($urandom_range(40, 900));
    test_random_mix(40);
    test_fill_table();
    drain();

    if (pending_results.size() != 0) mismatches++;
    $display("Covered %0d transactions: %0d hits, %0d refused inserts, final count %0d.",
             results_seen, hits_seen, refusals_seen, tbl_count);
    $display("Load limits from zero to every slot, plus a full-table probe.");
    if (mismatches == 0) begin
      $display("PASS fnv1a_linear_probe_hash_table");
    end else begin
      $display("FAIL fnv1a_linear_probe_hash_table");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fnvht_pkg.sv
rtl/fnvht_ram.sv
rtl/fnvht_hash.sv
rtl/fnvht_fifo.sv
rtl/fnvht_probe.sv
rtl/fnv1a_linear_probe_hash_table.sv
bench/tb.sv
